// ----- rtl/irc_tok_pkg.sv -----
// ============================================================================
// irc_tok_pkg
// Shared types and constants of the chat-line tokenizer: byte codes, parse
// modes, byte roles and the result record handed from parser to output stage.
// ============================================================================
package irc_tok_pkg;

    // Default argument limit
    localparam int IRC_MAX_ARGS = 16;

    // Byte codes the parser reacts to
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Position within the current line
    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_PREFIX    = 3'd1,
        MODE_CMD_FIRST = 3'd2,
        MODE_CMD       = 3'd3,
        MODE_ARG_SPACE = 3'd4,
        MODE_ARG       = 3'd5,
        MODE_TRAIL     = 3'd6,
        MODE_SKIP      = 3'd7
    } mode_t;

    // Role tag attached to each byte
    typedef enum logic [2:0] {
        ROLE_NICK   = 3'd0,
        ROLE_PREFIX = 3'd1,
        ROLE_CMD    = 3'd2,
        ROLE_ARG    = 3'd3,
        ROLE_DELIM  = 3'd4,
        ROLE_IGNORE = 3'd5,
        ROLE_END    = 3'd6
    } role_t;

    // One tagged byte with its line summary
    typedef struct packed {
        logic [7:0] byte_echo;
        role_t      role;
        logic [3:0] arg_index;
        logic       nick_present;
        logic [4:0] arg_count;
        logic       line_valid;
        logic       arg_overflow;
    } tok_result_t;

endpackage

// ----- rtl/irc_tok_parser.sv -----
// ============================================================================
// irc_tok_parser
// Line state and per-byte decode: classifies one byte against the current
// parse mode and updates the mode and line counters when told to advance.
// ============================================================================
module irc_tok_parser #(
    parameter int MAX_ARGS = irc_tok_pkg::IRC_MAX_ARGS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [7:0]               data_byte,
    input  logic                     stream_end,
    output irc_tok_pkg::tok_result_t res
);
    import irc_tok_pkg::*;

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int EXT_W = CNT_W + 5;
    localparam logic [CNT_W-1:0] ARG_LIMIT = CNT_W'(MAX_ARGS);

    mode_t            mode_reg,      mode_next;
    logic [CNT_W-1:0] args_reg,      args_next;
    logic             bang_reg,      bang_next;
    logic             cmd_good_reg,  cmd_good_next;
    logic             overflow_reg,  overflow_next;

    mode_t            eff_mode;
    logic             line_end;
    logic             arg_live;
    logic [EXT_W-1:0] args_ext;
    logic [EXT_W-1:0] idx_ext;

    // Decode common conditions; a line start without a colon acts as command start
    assign line_end = stream_end || (data_byte == CHAR_LF);
    assign eff_mode = ((mode_reg == MODE_START) && (data_byte != CHAR_COLON))
                      ? MODE_CMD_FIRST : mode_reg;
    assign arg_live = !overflow_reg && (args_reg != '0);
    assign args_ext = EXT_W'(args_reg);
    assign idx_ext  = args_ext - EXT_W'(1);

    // Next line state
    always_comb begin
        mode_next     = mode_reg;
        args_next     = args_reg;
        bang_next     = bang_reg;
        cmd_good_next = cmd_good_reg;
        overflow_next = overflow_reg;
        if (line_end) begin
            mode_next     = MODE_START;
            args_next     = '0;
            bang_next     = 1'b0;
            cmd_good_next = 1'b0;
            overflow_next = 1'b0;
        end else begin
            case (eff_mode)
                MODE_START: begin
                    mode_next = MODE_PREFIX;
                end
                MODE_PREFIX: begin
                    if (data_byte == CHAR_SPACE) begin
                        mode_next = MODE_CMD_FIRST;
                    end else if (data_byte == CHAR_BANG) begin
                        bang_next = 1'b1;
                    end
                end
                MODE_CMD_FIRST, MODE_CMD, MODE_ARG_SPACE, MODE_ARG: begin
                    if (data_byte == CHAR_CR) begin
                        mode_next = MODE_SKIP;
                    end else if (data_byte == CHAR_SPACE) begin
                        // open a new argument, or flag one too many
                        if (args_reg >= ARG_LIMIT) begin
                            overflow_next = 1'b1;
                        end else begin
                            args_next = args_reg + CNT_W'(1);
                        end
                        mode_next = MODE_ARG_SPACE;
                    end else if (eff_mode == MODE_CMD_FIRST || eff_mode == MODE_CMD) begin
                        if (eff_mode == MODE_CMD_FIRST && data_byte != CHAR_NUL) begin
                            cmd_good_next = 1'b1;
                        end
                        mode_next = MODE_CMD;
                    end else if (eff_mode == MODE_ARG_SPACE && data_byte == CHAR_COLON) begin
                        mode_next = MODE_TRAIL;
                    end else begin
                        mode_next = MODE_ARG;
                    end
                end
                MODE_TRAIL: begin
                    if (data_byte == CHAR_CR) begin
                        mode_next = MODE_SKIP;
                    end
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Role and summary of the current byte
    always_comb begin
        res           = '0;
        res.byte_echo = stream_end ? 8'h00 : data_byte;
        res.role      = ROLE_IGNORE;
        if (line_end) begin
            res.role         = ROLE_END;
            res.nick_present = bang_reg;
            res.arg_count    = args_ext[4:0];
            res.line_valid   = cmd_good_reg;
            res.arg_overflow = overflow_reg;
        end else begin
            case (eff_mode)
                MODE_START: begin
                    res.role = ROLE_DELIM;
                end
                MODE_PREFIX: begin
                    if (data_byte == CHAR_SPACE) begin
                        res.role = ROLE_DELIM;
                    end else if (data_byte == CHAR_BANG && !bang_reg) begin
                        res.role = ROLE_DELIM;
                    end else begin
                        res.role = bang_reg ? ROLE_PREFIX : ROLE_NICK;
                    end
                end
                MODE_CMD_FIRST, MODE_CMD: begin
                    if (data_byte == CHAR_CR || data_byte == CHAR_SPACE) begin
                        res.role = ROLE_DELIM;
                    end else begin
                        res.role = ROLE_CMD;
                    end
                end
                MODE_ARG_SPACE, MODE_ARG: begin
                    if (data_byte == CHAR_CR || data_byte == CHAR_SPACE) begin
                        res.role = ROLE_DELIM;
                    end else if (eff_mode == MODE_ARG_SPACE && data_byte == CHAR_COLON) begin
                        res.role = ROLE_DELIM;
                    end else if (arg_live) begin
                        res.role      = ROLE_ARG;
                        res.arg_index = idx_ext[3:0];
                    end
                end
                MODE_TRAIL: begin
                    if (data_byte == CHAR_CR) begin
                        res.role = ROLE_DELIM;
                    end else if (arg_live) begin
                        res.role      = ROLE_ARG;
                        res.arg_index = idx_ext[3:0];
                    end
                end
                default: begin
                    res.role = ROLE_IGNORE;
                end
            endcase
        end
    end

    // Commit the line state once the byte moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_START;
            args_reg     <= '0;
            bang_reg     <= 1'b0;
            cmd_good_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            args_reg     <= args_next;
            bang_reg     <= bang_next;
            cmd_good_reg <= cmd_good_next;
            overflow_reg <= overflow_next;
        end
    end

`ifndef SYNTH
    a_args_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        args_reg <= ARG_LIMIT)
        else $error("argument count above limit");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (args_reg == ARG_LIMIT))
        else $error("overflow flagged before the limit was reached");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.role == ROLE_END) |=>
            (mode_reg == MODE_START && args_reg == '0 && !bang_reg && !overflow_reg))
        else $error("line state not cleared after line end");
`endif

endmodule

// ----- rtl/irc_line_tokenizer_core.sv -----
// ============================================================================
// irc_line_tokenizer_core
// Streaming tokenizer for chat-protocol lines: tags every byte with its role
// and reports a line summary on each newline or end of stream.
// ============================================================================
// The block takes one byte per clock and gives exactly one result per byte,
// sustaining one byte per cycle with back-to-back requests on both sides.
// A byte is held in an input register, classified in one pass against the
// parse mode and line state registers (the only feedback loops) and written
// to the output register when that register is free, so its result passes
// the input register and then the output register before it is presented.
// While a result waits for m_tready the input register takes one more byte;
// a stalled output stops the pipe once those two stages are full.
// There is no memory and no clearing pass: the block is ready right after
// reset. Lines with an empty command are still reported, with line_valid low.
module irc_line_tokenizer_core #(
    parameter int MAX_ARGS = irc_tok_pkg::IRC_MAX_ARGS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] stream_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] byte_echo, [11:8] arg_index,
                                    // [12] nick_present, [17:13] arg_count,
                                    // [18] line_valid, [19] arg_overflow
    output logic [2:0]  m_tuser     // [2:0] role
);
    import irc_tok_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        out_valid_reg, out_valid_next;
    tok_result_t out_res_reg;

    logic        out_free;
    logic        advance;
    logic        s_fire;
    tok_result_t res;

    // Pipe control: a stage moves when the one after it is free
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser[0];
        end
    end

    // Classify the held byte
    irc_tok_parser #(
        .MAX_ARGS (MAX_ARGS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .data_byte  (in_byte_reg),
        .stream_end (in_end_reg),
        .res        (res)
    );

    // Register the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.role;
    assign m_tdata  = {4'b0000,
                       out_res_reg.arg_overflow,
                       out_res_reg.line_valid,
                       out_res_reg.arg_count,
                       out_res_reg.nick_present,
                       out_res_reg.arg_index,
                       out_res_reg.byte_echo};

endmodule
